/* design/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the WebSocket frame deframer
// Transfer payload structs, queue entry, parser phases, opcodes and the
// fixed pong reply bytes.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Input transfer: one received byte
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       segment_start;
    } t_wsd_in;

    // Output transfer: one result byte
    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_wsd_out;

    // Queue entry between parser and output stage; a ping entry expands to three bytes
    typedef struct packed {
        logic     is_ping;
        t_wsd_out item;
    } t_wsd_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_wsd_qstat;

    // Header parser phases
    typedef enum logic [2:0] {
        PH_HDR0,
        PH_LEN,
        PH_EXT,
        PH_KEY,
        PH_PAYLOAD,
        PH_DISCARD
    } t_wsd_phase;

    // Result kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_BIN   = 2'd1;
    localparam logic [1:0] KIND_PONG  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Opcodes and the bounds of the valid ranges
    localparam logic [3:0] OP_TEXT       = 4'h1;
    localparam logic [3:0] OP_BIN        = 4'h2;
    localparam logic [3:0] OP_LAST_DATA  = 4'h3;
    localparam logic [3:0] OP_FIRST_CTRL = 4'h8;
    localparam logic [3:0] OP_PING       = 4'h9;
    localparam logic [3:0] OP_LAST_CTRL  = 4'hB;

    // Length byte codes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Header byte counts (bytes still to come minus one)
    localparam logic [2:0] HCNT_EXT16 = 3'd1;
    localparam logic [2:0] HCNT_EXT64 = 3'd7;
    localparam logic [2:0] HCNT_KEY   = 3'd3;

    // Pong reply frame
    localparam logic [7:0] PONG_B0 = 8'h8A;
    localparam logic [7:0] PONG_B1 = 8'h01;
    localparam logic [7:0] PONG_B2 = 8'h20;

endpackage

/* design/wsd_front.sv */
// ----------------------------------------------------------------------------
// wsd_front: frame header parser
// Takes one byte per transfer, tracks the header phase, extended length and
// mask key, unmasks payload bytes and pushes results into the queue.
// ----------------------------------------------------------------------------
module wsd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  wsd_pkg::t_wsd_in i_in_data,
    output logic             o_in_stall,
    input  logic             i_full,
    output logic             o_push,
    output wsd_pkg::t_wsd_cmd o_push_data
);
    import wsd_pkg::*;

    t_wsd_phase  r_phase, n_phase, eff_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask, n_mask;
    logic [2:0]  r_hcnt, n_hcnt;
    logic [63:0] r_len, n_len;      // payload length, counts down during payload
    logic [31:0] r_key, n_key;
    logic [1:0]  r_pos, n_pos;      // key byte index

    logic        accept;
    logic [7:0]  rx;
    logic [3:0]  op;
    logic        op_invalid;
    logic [6:0]  len7;
    logic        len_ext;
    logic [63:0] ext_len;
    logic        last;
    logic [7:0]  kb;
    logic [7:0]  unmasked;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign rx         = i_in_data.rx_byte;
    assign eff_phase  = i_in_data.segment_start ? PH_HDR0 : r_phase;

    // Decode of the incoming byte
    assign op         = rx[3:0];
    assign op_invalid = ((op > OP_LAST_DATA) && (op < OP_FIRST_CTRL)) || (op > OP_LAST_CTRL);
    assign len7       = rx[6:0];
    assign len_ext    = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
    assign ext_len    = {r_len[55:0], rx};
    assign last       = (r_len == 64'd1);

    // Key byte for this payload position, first key byte first
    always_comb begin
        case (r_pos)
            2'd0:    kb = r_key[31:24];
            2'd1:    kb = r_key[23:16];
            2'd2:    kb = r_key[15:8];
            default: kb = r_key[7:0];
        endcase
    end
    assign unmasked = rx ^ kb;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (eff_phase)
                PH_HDR0:    n_phase = op_invalid ? PH_DISCARD : PH_LEN;
                PH_LEN: begin
                    if (len_ext)          n_phase = PH_EXT;
                    else if (rx[7])       n_phase = PH_KEY;
                    else if (len7 != '0)  n_phase = PH_PAYLOAD;
                    else                  n_phase = PH_HDR0;
                end
                PH_EXT: begin
                    if (r_hcnt == '0) begin
                        if (r_mask)                n_phase = PH_KEY;
                        else if (ext_len != '0)    n_phase = PH_PAYLOAD;
                        else                       n_phase = PH_HDR0;
                    end
                end
                PH_KEY: begin
                    if (r_hcnt == '0) n_phase = (r_len != '0) ? PH_PAYLOAD : PH_HDR0;
                end
                PH_PAYLOAD: begin
                    if (last) n_phase = PH_HDR0;
                end
                default:    n_phase = eff_phase;   // discard until next segment
            endcase
        end
    end

    // Header fields, unmasking and queue push
    always_comb begin
        n_opcode    = r_opcode;
        n_mask      = r_mask;
        n_hcnt      = r_hcnt;
        n_len       = r_len;
        n_key       = r_key;
        n_pos       = r_pos;
        o_push      = 1'b0;
        o_push_data = '0;
        if (accept) begin
            unique case (eff_phase)
                PH_HDR0: begin
                    n_opcode = op;
                    if (op_invalid) begin
                        o_push      = 1'b1;
                        o_push_data = '{is_ping: 1'b0,
                                        item: '{out_kind: KIND_ERROR, out_byte: {4'b0, op},
                                                last_of_run: 1'b0}};
                    end else if (op == OP_PING) begin
                        o_push      = 1'b1;
                        o_push_data = '{is_ping: 1'b1,
                                        item: '{out_kind: KIND_PONG, out_byte: PONG_B0,
                                                last_of_run: 1'b0}};
                    end
                end
                PH_LEN: begin
                    n_mask = rx[7];
                    if (len7 == LEN_EXT16) begin
                        n_hcnt = HCNT_EXT16;
                        n_len  = '0;
                    end else if (len7 == LEN_EXT64) begin
                        n_hcnt = HCNT_EXT64;
                        n_len  = '0;
                    end else begin
                        n_len = {57'b0, len7};
                        n_key = '0;
                        n_pos = '0;
                        if (rx[7]) n_hcnt = HCNT_KEY;
                    end
                end
                PH_EXT: begin
                    n_len = ext_len;
                    if (r_hcnt == '0) begin
                        n_key = '0;
                        n_pos = '0;
                        if (r_mask) n_hcnt = HCNT_KEY;
                    end else begin
                        n_hcnt = r_hcnt - 3'd1;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], rx};
                    if (r_hcnt != '0) n_hcnt = r_hcnt - 3'd1;
                end
                PH_PAYLOAD: begin
                    n_pos = r_pos + 2'd1;
                    n_len = r_len - 64'd1;
                    if (r_opcode == OP_TEXT) begin
                        o_push      = 1'b1;
                        o_push_data = '{is_ping: 1'b0,
                                        item: '{out_kind: KIND_TEXT, out_byte: unmasked,
                                                last_of_run: last}};
                    end else if (r_opcode == OP_BIN) begin
                        o_push      = 1'b1;
                        o_push_data = '{is_ping: 1'b0,
                                        item: '{out_kind: KIND_BIN, out_byte: unmasked,
                                                last_of_run: last}};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_hcnt  <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode <= n_opcode;
        r_mask   <= n_mask;
        r_len    <= n_len;
        r_key    <= n_key;
    end

endmodule

/* design/wsd_queue.sv */
// ----------------------------------------------------------------------------
// wsd_queue: short result queue
// Decouples the parser from the output stage; head entry is read directly.
// ----------------------------------------------------------------------------
module wsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wsd_pkg::t_wsd_cmd  i_push_data,
    input  logic               i_pop,
    output wsd_pkg::t_wsd_cmd  o_head,
    output wsd_pkg::t_wsd_qstat o_stat
);
    import wsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_wsd_cmd        r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Pointer and fill count update
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        if (i_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_push_data;
    end

endmodule

/* design/wsd_back.sv */
// ----------------------------------------------------------------------------
// wsd_back: output stage
// Pops queue entries into the output register and expands a ping entry into
// the three pong reply bytes.
// ----------------------------------------------------------------------------
module wsd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsd_pkg::t_wsd_cmd   i_head,
    input  wsd_pkg::t_wsd_qstat i_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    output wsd_pkg::t_wsd_out   o_out_data,
    input  logic                i_out_stall
);
    import wsd_pkg::*;

    // Pong byte still to send after the first one
    localparam logic [1:0] BEAT_IDLE = 2'd0;
    localparam logic [1:0] BEAT_B1   = 2'd1;
    localparam logic [1:0] BEAT_B2   = 2'd2;

    logic       r_valid, n_valid;
    t_wsd_out   r_data, n_data;
    logic [1:0] r_beat, n_beat;
    logic       load;

    assign load        = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    // Output register load
    always_comb begin
        o_pop   = 1'b0;
        n_valid = r_valid;
        n_data  = r_data;
        n_beat  = r_beat;
        if (load) begin
            if (r_beat == BEAT_B1) begin
                n_valid = 1'b1;
                n_data  = '{out_kind: KIND_PONG, out_byte: PONG_B1, last_of_run: 1'b0};
                n_beat  = BEAT_B2;
            end else if (r_beat == BEAT_B2) begin
                n_valid = 1'b1;
                n_data  = '{out_kind: KIND_PONG, out_byte: PONG_B2, last_of_run: 1'b1};
                n_beat  = BEAT_IDLE;
            end else if (!i_stat.empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                if (i_head.is_ping) begin
                    n_data = '{out_kind: KIND_PONG, out_byte: PONG_B0, last_of_run: 1'b0};
                    n_beat = BEAT_B1;
                end else begin
                    n_data = i_head.item;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_IDLE;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* design/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer: WebSocket frame header parser and payload unmasker
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one received byte
// per transfer; segment_start forces the byte to be read as a first header
// byte. Output channel (o_out_valid / i_out_stall / o_out_data) gives tagged
// text or binary payload bytes, pong reply bytes and invalid opcode errors.
// Throughput: one input byte per cycle while the result queue has room; a
// ping expands into three output bytes, all other bytes into at most one.
// A transferred byte's result is first written into the queue by the parser,
// then loaded from the queue into the output register when that can take it.
// The queue holds DEPTH entries; when the receiver stalls the output register
// holds its byte, the queue fills, and o_in_stall rises once it is full.
// Reset (synchronous, active low) empties the queue and output register and
// returns the parser to expecting a first header byte; no clearing pass.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  wsd_pkg::t_wsd_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output wsd_pkg::t_wsd_out o_out_data
);
    import wsd_pkg::*;

    logic       push;
    t_wsd_cmd   push_data;
    logic       pop;
    t_wsd_cmd   head;
    t_wsd_qstat qstat;

    // Parser
    wsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_full      (qstat.full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Result queue
    wsd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (qstat)
    );

    // Output stage
    wsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_stat      (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTH
    // Error results never close a run
    a_err_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_kind == KIND_ERROR) |-> !o_out_data.last_of_run)
        else $error("error result marked last");

    // Pong bytes come only from the fixed reply frame
    a_pong_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_kind == KIND_PONG) |->
        (o_out_data.out_byte == PONG_B0 || o_out_data.out_byte == PONG_B1 ||
         o_out_data.out_byte == PONG_B2))
        else $error("unexpected pong byte");

    // First pong byte taken is followed at once by the second
    a_pong_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.out_kind == KIND_PONG &&
         o_out_data.out_byte == PONG_B0) |=>
        (o_out_valid && o_out_data.out_kind == KIND_PONG && o_out_data.out_byte == PONG_B1))
        else $error("pong reply broken");

    // No push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.full |-> !push)
        else $error("queue overflow");
`endif

endmodule

/* verif/tb_websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer: self-checking bench for the frame deframer
// Feeds WebSocket frame byte streams (well-formed frames of every opcode and
// length form, masked and not, plus noise and cut-short frames) through the
// valid/stall input, predicts every result byte in step with each input
// transfer and checks the output transfers in order. Idling is varied on both
// sides, and one long receiver hold-off drives the block into back-pressure.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;

    import wsd_pkg::*;

    // Opcodes the package leaves unnamed
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_PONG  = 4'hA;
    localparam logic [3:0] OP_MAX   = 4'hF;

    // Length encodings of a generated frame
    localparam int LF_SHORT = 0;
    localparam int LF_EXT16 = 1;
    localparam int LF_EXT64 = 2;

    localparam int PHASE_BYTES   = 100;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 8;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_wsd_in   in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_wsd_out  out_data;

    // Bytes waiting to be offered, and result bytes predicted but not yet seen
    t_wsd_in   rx_bytes_q[$];
    t_wsd_out  deframed_q[$];

    // Predicted parser state
    t_wsd_phase  rx_phase   = PH_HDR0;
    logic [3:0]  frm_op     = '0;
    logic        frm_masked = 1'b0;
    logic [2:0]  hdr_left   = '0;
    logic [63:0] frm_len    = '0;
    logic [31:0] frm_key    = '0;
    logic [63:0] frm_pos    = '0;

    // Idling control and the receiver hold-off
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req    = 1'b0;
    logic hold_begun  = 1'b0;
    int   hold_left   = 0;

    bit   need_sync   = 1'b0;
    int   n_queued    = 0;
    int   n_sent      = 0;
    int   n_results   = 0;
    int   n_pong      = 0;
    int   n_err       = 0;
    int   n_stalled   = 0;
    int   mismatches  = 0;

    websocket_frame_deframer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    task automatic push_result(input logic [1:0] kind, input logic [7:0] b, input logic last);
        t_wsd_out r;
        r.out_kind    = kind;
        r.out_byte    = b;
        r.last_of_run = last;
        deframed_q.push_back(r);
    endtask

    // Length known: key bytes next, payload next, or straight on to a new frame
    task automatic length_known();
        frm_key = '0;
        frm_pos = '0;
        if (frm_masked) begin
            hdr_left = HCNT_KEY;
            rx_phase = PH_KEY;
        end else if (frm_len != '0) begin
            rx_phase = PH_PAYLOAD;
        end else begin
            rx_phase = PH_HDR0;
        end
    endtask

    task automatic deframe_byte(input t_wsd_in rx);
        logic [3:0] op;
        logic [7:0] kb;
        logic [7:0] v;
        logic       last;
        if (rx.segment_start) rx_phase = PH_HDR0;
        case (rx_phase)
            PH_HDR0: begin
                op     = rx.rx_byte[3:0];
                frm_op = op;
                if ((op > OP_LAST_DATA && op < OP_FIRST_CTRL) || op > OP_LAST_CTRL) begin
                    push_result(KIND_ERROR, {4'h0, op}, 1'b0);
                    rx_phase = PH_DISCARD;
                end else begin
                    if (op == OP_PING) begin
                        push_result(KIND_PONG, PONG_B0, 1'b0);
                        push_result(KIND_PONG, PONG_B1, 1'b0);
                        push_result(KIND_PONG, PONG_B2, 1'b1);
                    end
                    rx_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                frm_masked = rx.rx_byte[7];
                frm_len    = '0;
                if (rx.rx_byte[6:0] == LEN_EXT16) begin
                    hdr_left = HCNT_EXT16;
                    rx_phase = PH_EXT;
                end else if (rx.rx_byte[6:0] == LEN_EXT64) begin
                    hdr_left = HCNT_EXT64;
                    rx_phase = PH_EXT;
                end else begin
                    frm_len = 64'(rx.rx_byte[6:0]);
                    length_known();
                end
            end
            PH_EXT: begin
                frm_len = {frm_len[55:0], rx.rx_byte};
                if (hdr_left == '0) length_known();
                else hdr_left = hdr_left - 3'd1;
            end
            PH_KEY: begin
                frm_key = {frm_key[23:0], rx.rx_byte};
                if (hdr_left == '0) rx_phase = (frm_len != '0) ? PH_PAYLOAD : PH_HDR0;
                else hdr_left = hdr_left - 3'd1;
            end
            PH_PAYLOAD: begin
                // key bytes taken most significant first, cycling every four bytes
                kb      = 8'(frm_key >> (8 * (3 - int'(frm_pos[1:0]))));
                v       = rx.rx_byte ^ kb;
                frm_pos = frm_pos + 64'd1;
                last    = (frm_pos >= frm_len);
                if (frm_op == OP_TEXT) push_result(KIND_TEXT, v, last);
                else if (frm_op == OP_BIN) push_result(KIND_BIN, v, last);
                if (last) rx_phase = PH_HDR0;
            end
            default: begin
                // discarding until the next segment start
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input logic seg);
        t_wsd_in x;
        x.rx_byte       = b;
        x.segment_start = seg;
        rx_bytes_q.push_back(x);
        n_queued++;
    endtask

    // One frame; only 'sent' payload bytes of 'len' go out, so it may be cut short
    task automatic add_frame(input logic [3:0] op, input logic seg, input logic masked,
                             input int form, input logic [63:0] len, input int sent);
        add_byte({4'($urandom), op}, seg);
        case (form)
            LF_EXT16: begin
                add_byte({masked, LEN_EXT16}, 1'b0);
                add_byte(len[15:8], 1'b0);
                add_byte(len[7:0], 1'b0);
            end
            LF_EXT64: begin
                add_byte({masked, LEN_EXT64}, 1'b0);
                for (int i = 7; i >= 0; i--) add_byte(len[8*i +: 8], 1'b0);
            end
            default: add_byte({masked, len[6:0]}, 1'b0);
        endcase
        if (masked) repeat (4) add_byte(8'($urandom), 1'b0);
        repeat (sent) add_byte(8'($urandom), 1'b0);
    endtask

    task automatic add_random_frame();
        int          r;
        int          form;
        int          sent;
        logic [3:0]  op;
        logic [63:0] len;
        logic        seg;
        logic        masked;
        logic [3:0]  other_ops[5];
        other_ops = '{OP_CONT, OP_LAST_DATA, OP_FIRST_CTRL, OP_PONG, OP_LAST_CTRL};

        // noise: stray bytes, after which the next frame must resync
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom), 1'($urandom));
            need_sync = 1'b1;
            return;
        end

        seg       = need_sync || ($urandom_range(99) < 20);
        need_sync = 1'b0;

        r = $urandom_range(99);
        if (r < 32)      op = OP_TEXT;
        else if (r < 62) op = OP_BIN;
        else if (r < 72) op = OP_PING;
        else if (r < 86) op = other_ops[$urandom_range(4)];
        else if ($urandom_range(1) == 0)
            op = 4'($urandom_range(int'(OP_LAST_DATA) + 1, int'(OP_FIRST_CTRL) - 1));
        else
            op = 4'($urandom_range(int'(OP_LAST_CTRL) + 1, int'(OP_MAX)));

        // invalid opcode: error, then a few bytes to be thrown away
        if ((op > OP_LAST_DATA && op < OP_FIRST_CTRL) || op > OP_LAST_CTRL) begin
            add_byte({4'($urandom), op}, seg);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0);
            need_sync = 1'b1;
            return;
        end

        masked = ($urandom_range(99) < 60);
        r      = $urandom_range(99);
        if (r < 70) begin
            form = LF_SHORT;
            len  = ($urandom_range(19) == 0) ? 64'($urandom_range(125)) : 64'($urandom_range(12));
        end else if (r < 90) begin
            form = LF_EXT16;
            len  = ($urandom_range(9) == 0) ? 64'($urandom_range(65535)) : 64'($urandom_range(20));
        end else begin
            form = LF_EXT64;
            len  = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(12));
        end

        // long frames and a share of the others are cut short by a new segment
        if (len > 64'd300 || $urandom_range(99) < 8) begin
            sent      = $urandom_range((len > 64'd8) ? 8 : int'(len));
            need_sync = 1'b1;
        end else begin
            sent = int'(len);
        end
        add_frame(op, seg, masked, form, len, sent);
    endtask

    task automatic wait_drained();
        int spin;
        spin = 0;
        while ((rx_bytes_q.size() != 0 || in_valid || deframed_q.size() != 0)
               && spin < DRAIN_LIMIT) begin
            @(posedge clk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: predicts on every transfer, holds the byte while stalled
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_rx
        logic took;
        took = in_valid && !in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_stall) n_stalled++;
            if (took) begin
                deframe_byte(in_data);
                n_sent++;
            end
            if (!in_valid || took) begin
                if (rx_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= rx_bytes_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor and receiver stall
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : watch_out
        t_wsd_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (out_data.out_kind == KIND_PONG)  n_pong++;
                if (out_data.out_kind == KIND_ERROR) n_err++;
                if (deframed_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result kind %0d byte %02h last %0b",
                             $time, out_data.out_kind, out_data.out_byte,
                             out_data.last_of_run);
                end else begin
                    want = deframed_q.pop_front();
                    if (out_data.out_kind !== want.out_kind
                        || out_data.out_byte !== want.out_byte
                        || out_data.last_of_run !== want.last_of_run) begin
                        mismatches++;
                        $display("%0t: expected kind/byte/last %0d/%02h/%0b, got %0d/%02h/%0b",
                                 $time, want.out_kind, want.out_byte, want.last_of_run,
                                 out_data.out_kind, out_data.out_byte,
                                 out_data.last_of_run);
                    end
                end
            end
            // long hold-off once requested, random stalls otherwise
            if (hold_req && !hold_begun) begin
                hold_begun <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                out_stall  <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int target;

        // directed: masked text, unmasked binary with 16-bit length
        add_frame(OP_TEXT, 1'b1, 1'b1, LF_SHORT, 64'd3, 3);
        add_frame(OP_BIN, 1'b0, 1'b0, LF_EXT16, 64'd2, 2);
        // invalid opcode with all bits set, then a zero byte that is discarded
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        // ping carrying one masked byte, then an empty text frame
        add_frame(OP_PING, 1'b1, 1'b1, LF_SHORT, 64'd1, 1);
        add_frame(OP_TEXT, 1'b0, 1'b0, LF_SHORT, 64'd0, 0);
        // 64-bit length with the top bit set, abandoned by a new segment
        add_frame(OP_TEXT, 1'b0, 1'b0, LF_EXT64, '1, 2);
        need_sync = 1'b1;

        // first phase: sender idles lightly, receiver heavily
        tx_idle_pct = 27;
        rx_idle_pct = 80;
        target = n_queued + PHASE_BYTES;
        while (n_queued < target) add_random_frame();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // second phase: the other way round
        tx_idle_pct <= 80;
        rx_idle_pct <= 27;
        target = n_queued + PHASE_BYTES;
        while (n_queued < target) add_random_frame();
        wait_drained();

        // third phase: no idling, one long hold-off against a long text frame
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        add_frame(OP_TEXT, 1'b1, 1'b1, LF_SHORT, 64'd60, 60);
        hold_req <= 1'b1;
        target = n_queued + PHASE_BYTES;
        while (n_queued < target) add_random_frame();
        wait_drained();

        if (deframed_q.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, deframed_q.size());
        end

        $display("Sent %0d bytes, checked %0d results (%0d pong, %0d opcode errors).",
                 n_sent, n_results, n_pong, n_err);
        $display("Input held back by the block on %0d cycles; three idling profiles run.",
                 n_stalled);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("%0t: run timed out", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
